/* design/rcs_pkg.sv */
// shared constants and types for the rolling checksum chunk splitter
package rcs_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MASK_BITS_W = 5;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned OUT_LEN_W  = 24;

  // default sizing
  localparam int unsigned DEFAULT_WINDOW_BYTES = 64;
  localparam int unsigned DEFAULT_LENGTH_BITS  = 24;

  // rollsum character offset
  localparam int unsigned CHAR_OFFSET = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLICE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLICE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_MASK = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0]       MIN_SLICE_RESET  = 24'd65536;
  localparam logic [CFG_W-1:0]       MAX_SLICE_RESET  = 24'd10485760;
  localparam logic [MASK_BITS_W-1:0] SPLIT_MASK_RESET = 5'd18;

  // request from the splitter core to the window store
  typedef struct packed {
    logic              advance;
    logic              restart;
    logic [BYTE_W-1:0] data;
  } win_ctrl_t;

endpackage

/* design/rcs_if.sv */
// valid/ready channel interfaces for input bytes and split results
interface rcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcs_out_if;
  logic        valid;
  logic        ready;
  logic        cut_before;
  logic [23:0] cut_length;
  logic        stream_end;
  logic [23:0] final_length;

  modport source (output valid, output cut_before, output cut_length,
                  output stream_end, output final_length, input ready);
  modport sink   (input valid, input cut_before, input cut_length,
                  input stream_end, input final_length, output ready);
endinterface

/* design/rcs_window.sv */
// sliding byte window: memory with valid bits and a prefetched oldest byte
module rcs_window #(
  parameter int unsigned WINDOW_BYTES = rcs_pkg::DEFAULT_WINDOW_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  rcs_pkg::win_ctrl_t ctrl,
  output logic [7:0]        drop_byte
);
  import rcs_pkg::*;

  localparam int unsigned IDX_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_BYTES - 1);

  logic [BYTE_W-1:0]       mem [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] valid;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_inc;
  logic [IDX_W-1:0]        idx_next;
  logic [IDX_W-1:0]        rd_addr;
  logic [BYTE_W-1:0]       rd_data;

  // next position, wrapping at the window size
  assign idx_inc  = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  assign idx_next = ctrl.restart ? '0 : idx_inc;

  // read ahead the byte that the next request will drop
  assign rd_addr = ctrl.advance ? idx_next : idx;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      mem[idx] <= ctrl.data;
    end
    rd_data <= mem[rd_addr];
  end

  // position and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      valid <= '0;
    end else if (ctrl.advance) begin
      idx <= idx_next;
      if (ctrl.restart) begin
        valid <= '0;
      end else begin
        valid[idx] <= 1'b1;
      end
    end
  end

  // never-written entries read as zero
  assign drop_byte = valid[idx] ? rd_data : '0;

endmodule

/* design/rolling_checksum_chunk_splitter.sv */
// Content-defined chunk splitter: takes one stream byte per request and
// returns one result per byte. Throughput is one byte per clock unless the
// result side stalls; each byte passes an input register, then the rollsum
// update and cut decision into the result register. The window of WINDOW_BYTES
// bytes sits in a memory whose oldest byte is read ahead, so the update is one
// 32-bit add chain plus a masked compare. The stream is restarted after the
// byte flagged last. The user writes configuration through a plain write port
// only while no request is in flight (the block does not enforce it); index 0
// is the minimum slice length, 1 the maximum, 2 the mask bit count, 3 ignored.
module rolling_checksum_chunk_splitter #(
  parameter int unsigned WINDOW_BYTES = rcs_pkg::DEFAULT_WINDOW_BYTES,
  parameter int unsigned LENGTH_BITS  = rcs_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  rcs_in_if.sink                       in,
  rcs_out_if.source                    out,
  input  logic                         cfg_write,
  input  logic [rcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcs_pkg::CFG_W-1:0]    cfg_data
);
  import rcs_pkg::*;

  localparam int unsigned CMP_W = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [SUM_W-1:0] FIRST_INIT  = SUM_W'(WINDOW_BYTES * CHAR_OFFSET);
  localparam logic [SUM_W-1:0] SECOND_INIT =
    SUM_W'(WINDOW_BYTES * (WINDOW_BYTES - 1) * CHAR_OFFSET);

  // configuration registers
  logic [CFG_W-1:0]       min_slice_bytes;
  logic [CFG_W-1:0]       max_slice_bytes;
  logic [MASK_BITS_W-1:0] split_mask_bits;

  // input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;

  // stream state
  logic [SUM_W-1:0]       first_sum;
  logic [SUM_W-1:0]       second_sum;
  logic [LENGTH_BITS-1:0] slice_length;

  // result register
  logic                 out_valid;
  logic                 out_cut;
  logic [OUT_LEN_W-1:0] out_cut_len;
  logic                 out_end;
  logic [OUT_LEN_W-1:0] out_fin_len;

  // datapath
  logic                   advance;
  logic [BYTE_W-1:0]      drop_byte;
  win_ctrl_t              win_ctrl;
  logic [SUM_W-1:0]       first_sum_next;
  logic [SUM_W-1:0]       drop_term;
  logic [SUM_W-1:0]       second_sum_next;
  logic [SUM_W-1:0]       mask;
  logic                   content_hit;
  logic [CMP_W-1:0]       len_ext;
  logic [CMP_W-1:0]       min_ext;
  logic [CMP_W-1:0]       max_ext;
  logic                   cut;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [LENGTH_BITS-1:0] slice_length_next;
  logic [CMP_W-1:0]       new_len_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_slice_bytes <= MIN_SLICE_RESET;
      max_slice_bytes <= MAX_SLICE_RESET;
      split_mask_bits <= SPLIT_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MIN_SLICE:  min_slice_bytes <= cfg_data;
        CFG_MAX_SLICE:  max_slice_bytes <= cfg_data;
        CFG_SPLIT_MASK: split_mask_bits <= cfg_data[MASK_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the core moves when the result register is free or drains
  assign advance  = in_valid_q && (!out_valid || out.ready);
  assign in.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in.ready) begin
      in_valid_q <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      in_data_q <= in.data_byte;
      in_last_q <= in.last_byte;
    end
  end

  // window store
  assign win_ctrl.advance = advance;
  assign win_ctrl.restart = in_last_q;
  assign win_ctrl.data    = in_data_q;

  rcs_window #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (win_ctrl),
    .drop_byte(drop_byte)
  );

  // rollsum update
  assign first_sum_next  = first_sum + SUM_W'(in_data_q) - SUM_W'(drop_byte);
  assign drop_term       = SUM_W'(WINDOW_BYTES) * (SUM_W'(drop_byte) + SUM_W'(CHAR_OFFSET));
  assign second_sum_next = second_sum + first_sum_next - drop_term;

  // content test on the low second-sum bits
  assign mask        = (SUM_W'(1) << split_mask_bits) - SUM_W'(1);
  assign content_hit = (second_sum_next & mask) == mask;

  // cut decision
  assign len_ext = CMP_W'(slice_length);
  assign min_ext = CMP_W'(min_slice_bytes);
  assign max_ext = CMP_W'(max_slice_bytes);
  assign cut     = (len_ext > min_ext) && ((len_ext >= max_ext) || content_hit);

  // saturating slice length
  assign len_inc           = (slice_length == LEN_MAX) ? LEN_MAX
                                                       : slice_length + LENGTH_BITS'(1);
  assign slice_length_next = cut ? LENGTH_BITS'(1) : len_inc;
  assign new_len_ext       = CMP_W'(slice_length_next);

  // stream state, back to its start after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sum    <= FIRST_INIT;
      second_sum   <= SECOND_INIT;
      slice_length <= '0;
    end else if (advance) begin
      if (in_last_q) begin
        first_sum    <= FIRST_INIT;
        second_sum   <= SECOND_INIT;
        slice_length <= '0;
      end else begin
        first_sum    <= first_sum_next;
        second_sum   <= second_sum_next;
        slice_length <= slice_length_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cut     <= cut;
      out_cut_len <= cut ? len_ext[OUT_LEN_W-1:0] : '0;
      out_end     <= in_last_q;
      out_fin_len <= in_last_q ? new_len_ext[OUT_LEN_W-1:0] : '0;
    end
  end

  assign out.valid        = out_valid;
  assign out.cut_before   = out_cut;
  assign out.cut_length   = out_cut_len;
  assign out.stream_end   = out_end;
  assign out.final_length = out_fin_len;

endmodule
